FILE: rtl/bgr_pkg.sv
// ----------------------------------------------------------------------------
// bgr_pkg
// Shared types and constants of the bilinear grid resampler.
// ----------------------------------------------------------------------------
package bgr_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int FRAC_BITS  = 16;

  localparam int SPAN_W     = 6;
  localparam int IDX_W      = 6;
  localparam int COORD_W    = 32;
  localparam int NUM_W      = 2 * SPAN_W;
  localparam int QUO_W      = NUM_W + FRAC_BITS;
  localparam int DIV_STAGES = QUO_W;
  localparam int DEPTH      = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CFG_IDX_W  = 2;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int MUL_W      = DIFF_W + FRAC_BITS + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUT_ROWS = 2'd0,
    REG_OUT_COLS = 2'd1,
    REG_SRC_ROWS = 2'd2,
    REG_SRC_COLS = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef logic [2:0][COORD_W-1:0] point_t;

  typedef struct packed {
    action_e             action;
    logic                err;
    logic [IDX_W-1:0]    row;
    logic [IDX_W-1:0]    col;
    logic                row_last;
    logic                col_last;
    point_t              pt;
    logic [QUO_W-1:0]    num_r;
    logic [QUO_W-1:0]    num_c;
    logic [SPAN_W-1:0]   den_r;
    logic [SPAN_W-1:0]   den_c;
    logic [SPAN_W-1:0]   rem_r;
    logic [SPAN_W-1:0]   rem_c;
    logic [QUO_W-1:0]    quo_r;
    logic [QUO_W-1:0]    quo_c;
  } div_t;

endpackage

FILE: rtl/bilinear_grid_resampler_top.sv
// ----------------------------------------------------------------------------
// bilinear_grid_resampler_top
// Resamples a stored grid of Q16.16 points to a new grid size by bilinear
// interpolation.
// ----------------------------------------------------------------------------
// The block takes one item in every cycle unless the output stalls, and passes a
// query through one entry stage, 28 stages of a one-bit-per-stage divider
// that maps the output index onto the source grid, one registered read of the
// two duplicated grid memories, and six stages for the two lerp passes. Loads
// travel the same pipeline and write the grid in the read stage, so items
// take effect in order. A stalled result holds the whole pipeline. The grid
// has no reset; a query must only touch entries that were loaded.
module bilinear_grid_resampler_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bgr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bgr_pkg::SPAN_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [bgr_pkg::IDX_W-1:0]      row_i,
  input  logic [bgr_pkg::IDX_W-1:0]      col_i,
  input  logic signed [bgr_pkg::COORD_W-1:0] in_x_i,
  input  logic signed [bgr_pkg::COORD_W-1:0] in_y_i,
  input  logic signed [bgr_pkg::COORD_W-1:0] in_z_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [bgr_pkg::COORD_W-1:0] out_x_o,
  output logic signed [bgr_pkg::COORD_W-1:0] out_y_o,
  output logic signed [bgr_pkg::COORD_W-1:0] out_z_o,
  output logic                           range_error_o
);

  localparam int NS = bgr_pkg::DIV_STAGES;
  localparam int FB = bgr_pkg::FRAC_BITS;
  localparam int CW = bgr_pkg::COORD_W;

  logic [bgr_pkg::SPAN_W-1:0] out_rows_q, out_cols_q, src_rows_q, src_cols_q;
  logic [bgr_pkg::SPAN_W-1:0] orow, ocol, srow, scol;
  logic en;

  bgr_pkg::div_t pipe_q [NS+1];
  logic          vld_q  [NS+1];
  bgr_pkg::div_t entry_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_rows_q <= bgr_pkg::SPAN_W'(1);
      out_cols_q <= bgr_pkg::SPAN_W'(1);
      src_rows_q <= bgr_pkg::SPAN_W'(1);
      src_cols_q <= bgr_pkg::SPAN_W'(1);
    end else if (cfg_we_i) begin
      case (bgr_pkg::cfg_reg_e'(cfg_idx_i))
        bgr_pkg::REG_OUT_ROWS: out_rows_q <= cfg_wdata_i;
        bgr_pkg::REG_OUT_COLS: out_cols_q <= cfg_wdata_i;
        bgr_pkg::REG_SRC_ROWS: src_rows_q <= cfg_wdata_i;
        bgr_pkg::REG_SRC_COLS: src_cols_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign orow = (out_rows_q == '0) ? bgr_pkg::SPAN_W'(1) : out_rows_q;
  assign ocol = (out_cols_q == '0) ? bgr_pkg::SPAN_W'(1) : out_cols_q;
  assign srow = (src_rows_q == '0) ? bgr_pkg::SPAN_W'(1) : src_rows_q;
  assign scol = (src_cols_q == '0) ? bgr_pkg::SPAN_W'(1) : src_cols_q;

  logic out_vld_q;
  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  always_comb begin
    entry_d          = '0;
    entry_d.action   = bgr_pkg::action_e'(action_i);
    entry_d.err      = (row_i > orow) || (col_i > ocol);
    entry_d.row      = row_i;
    entry_d.col      = col_i;
    entry_d.row_last = (row_i == orow);
    entry_d.col_last = (col_i == ocol);
    entry_d.pt       = {in_z_i, in_y_i, in_x_i};
    entry_d.num_r    = {bgr_pkg::NUM_W'(row_i * srow), {FB{1'b0}}};
    entry_d.num_c    = {bgr_pkg::NUM_W'(col_i * scol), {FB{1'b0}}};
    entry_d.den_r    = orow;
    entry_d.den_c    = ocol;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 0; k < NS; k++) vld_q[k+1] <= vld_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pipe_q[0] <= entry_d;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_div
    bgr_pkg::div_t step_d;
    logic [bgr_pkg::SPAN_W:0] tr, tc;
    logic ger, gec;
    always_comb begin
      step_d = pipe_q[k];
      tr  = {pipe_q[k].rem_r, pipe_q[k].num_r[NS-1-k]};
      tc  = {pipe_q[k].rem_c, pipe_q[k].num_c[NS-1-k]};
      ger = tr >= {1'b0, pipe_q[k].den_r};
      gec = tc >= {1'b0, pipe_q[k].den_c};
      step_d.rem_r = ger ? bgr_pkg::SPAN_W'(tr - {1'b0, pipe_q[k].den_r})
                         : tr[bgr_pkg::SPAN_W-1:0];
      step_d.rem_c = gec ? bgr_pkg::SPAN_W'(tc - {1'b0, pipe_q[k].den_c})
                         : tc[bgr_pkg::SPAN_W-1:0];
      step_d.quo_r = {pipe_q[k].quo_r[NS-2:0], ger};
      step_d.quo_c = {pipe_q[k].quo_c[NS-2:0], gec};
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        pipe_q[k+1] <= step_d;
      end
    end
  end

  bgr_pkg::div_t last;
  logic [bgr_pkg::IDX_W:0] iy, ix, cy, bx;
  logic [bgr_pkg::ADDR_W-1:0] addr_w, addr_a, addr_b, addr_c, addr_d;
  logic wr_en;

  assign last   = pipe_q[NS];
  assign iy     = {1'b0, last.quo_r[FB +: bgr_pkg::IDX_W]};
  assign ix     = {1'b0, last.quo_c[FB +: bgr_pkg::IDX_W]};
  assign cy     = last.row_last ? iy : iy + 1'b1;
  assign bx     = last.col_last ? ix : ix + 1'b1;
  assign addr_w = bgr_pkg::ADDR_W'(last.row * bgr_pkg::MAX_COLS + last.col);
  assign addr_a = bgr_pkg::ADDR_W'(iy * bgr_pkg::MAX_COLS + ix);
  assign addr_b = bgr_pkg::ADDR_W'(iy * bgr_pkg::MAX_COLS + bx);
  assign addr_c = bgr_pkg::ADDR_W'(cy * bgr_pkg::MAX_COLS + ix);
  assign addr_d = bgr_pkg::ADDR_W'(cy * bgr_pkg::MAX_COLS + bx);
  assign wr_en  = en && vld_q[NS] && (last.action == bgr_pkg::ACT_LOAD) &&
                  (last.row < bgr_pkg::MAX_ROWS) && (last.col < bgr_pkg::MAX_COLS);

  bgr_pkg::point_t mem_top_q [bgr_pkg::DEPTH];
  bgr_pkg::point_t mem_bot_q [bgr_pkg::DEPTH];
  bgr_pkg::point_t rd_a_q, rd_b_q, rd_c_q, rd_d_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_top_q[addr_w] <= last.pt;
    end
    if (en) begin
      rd_a_q <= mem_top_q[addr_a];
      rd_b_q <= mem_top_q[addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_bot_q[addr_w] <= last.pt;
    end
    if (en) begin
      rd_c_q <= mem_bot_q[addr_c];
      rd_d_q <= mem_bot_q[addr_d];
    end
  end

  logic r_vld_q, r_err_q, ok_a_q, ok_b_q, ok_c_q, ok_d_q;
  logic [FB-1:0] r_fy_q, r_fx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
    end else if (en) begin
      r_vld_q <= vld_q[NS] && (last.action == bgr_pkg::ACT_QUERY);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_err_q <= last.err;
      r_fy_q  <= last.quo_r[FB-1:0];
      r_fx_q  <= last.quo_c[FB-1:0];
      ok_a_q  <= (iy < bgr_pkg::MAX_ROWS) && (ix < bgr_pkg::MAX_COLS);
      ok_b_q  <= (iy < bgr_pkg::MAX_ROWS) && (bx < bgr_pkg::MAX_COLS);
      ok_c_q  <= (cy < bgr_pkg::MAX_ROWS) && (ix < bgr_pkg::MAX_COLS);
      ok_d_q  <= (cy < bgr_pkg::MAX_ROWS) && (bx < bgr_pkg::MAX_COLS);
    end
  end

  logic [5:0] s_vld_q;
  logic [5:0] s_err_q;
  logic [FB-1:0] s_fy_q [4];
  logic [FB-1:0] s_fx_q [1];
  bgr_pkg::point_t pa, pb, pc, pd;
  logic signed [bgr_pkg::DIFF_W-1:0] dab_q [3], dcd_q [3], dp_q [3];
  logic signed [bgr_pkg::MUL_W-1:0]  m1_q [3], m2_q [3], mp_q [3];
  logic signed [CW-1:0] a1_q [3], c1_q [3], a2_q [3], c2_q [3];
  logic signed [CW-1:0] p1_q [3], p2_q [3], p1b_q [3], p1c_q [3], res_q [3];

  assign pa = ok_a_q ? rd_a_q : '0;
  assign pb = ok_b_q ? rd_b_q : '0;
  assign pc = ok_c_q ? rd_c_q : '0;
  assign pd = ok_d_q ? rd_d_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= '0;
    end else if (en) begin
      s_vld_q <= {s_vld_q[4:0], r_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_err_q   <= {s_err_q[4:0], r_err_q};
      s_fy_q[0] <= r_fy_q;
      for (int k = 1; k < 4; k++) s_fy_q[k] <= s_fy_q[k-1];
      s_fx_q[0] <= r_fx_q;
      for (int k = 0; k < 3; k++) begin
        dab_q[k] <= $signed({pb[k][CW-1], pb[k]}) - $signed({pa[k][CW-1], pa[k]});
        dcd_q[k] <= $signed({pd[k][CW-1], pd[k]}) - $signed({pc[k][CW-1], pc[k]});
        a1_q[k]  <= $signed(pa[k]);
        c1_q[k]  <= $signed(pc[k]);
        m1_q[k]  <= dab_q[k] * $signed({1'b0, s_fx_q[0]});
        m2_q[k]  <= dcd_q[k] * $signed({1'b0, s_fx_q[0]});
        a2_q[k]  <= a1_q[k];
        c2_q[k]  <= c1_q[k];
        p1_q[k]  <= a2_q[k] + CW'(m1_q[k] >>> FB);
        p2_q[k]  <= c2_q[k] + CW'(m2_q[k] >>> FB);
        dp_q[k]  <= $signed({p2_q[k][CW-1], p2_q[k]}) - $signed({p1_q[k][CW-1], p1_q[k]});
        p1b_q[k] <= p1_q[k];
        mp_q[k]  <= dp_q[k] * $signed({1'b0, s_fy_q[3]});
        p1c_q[k] <= p1b_q[k];
        res_q[k] <= s_err_q[4] ? '0 : p1c_q[k] + CW'(mp_q[k] >>> FB);
      end
    end
  end

  assign out_vld_q     = s_vld_q[5];
  assign out_valid_o   = out_vld_q;
  assign out_x_o       = res_q[0];
  assign out_y_o       = res_q[1];
  assign out_z_o       = res_q[2];
  assign range_error_o = s_err_q[5];

endmodule
